FILE: sv/sklp_pkg.sv
// Package for the string-keyed linear-probe table.
// Holds sizes, opcode and status codes and the request and response types.
package sklp_pkg;
   localparam int TableSize  = 4096;
   localparam int MaxNameLen = 32;
   localparam int SlotW      = $clog2(TableSize);
   localparam int CharW      = $clog2(MaxNameLen);
   localparam int LenW       = $clog2(MaxNameLen + 1);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_PRESENT  = 3'd1;
   localparam logic [2:0] ST_REMOVED  = 3'd2;
   localparam logic [2:0] ST_FOUND    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;
   localparam logic [2:0] ST_TOOLONG  = 3'd6;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  character;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] slot;
   } rsp_type;
endpackage

FILE: sv/sklp_if.sv
// Valid/ready channel interface.
// Depends on sklp_pkg for the request and response payload types.
interface sklp_req_if;
   logic                 valid;
   logic                 ready;
   sklp_pkg::req_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sklp_rsp_if;
   logic                 valid;
   logic                 ready;
   sklp_pkg::rsp_type    data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/sklp_store.sv
// Entry store: name bytes, lengths and occupied bits.
// Depends on sklp_pkg. Registered reads; occupied bits cleared by sweep.
module sklp_store (
   input  logic                          clock,
   input  logic                          chr_we,
   input  logic [sklp_pkg::SlotW+sklp_pkg::CharW-1:0] chr_addr,
   input  logic [7:0]                    chr_wdata,
   output logic [7:0]                    chr_rdata,
   input  logic                          ent_we,
   input  logic [sklp_pkg::SlotW-1:0]    ent_addr,
   input  logic [sklp_pkg::LenW-1:0]     ent_wlen,
   input  logic                          ent_wocc,
   output logic [sklp_pkg::LenW-1:0]     ent_rlen,
   output logic                          ent_rocc
);
   logic [7:0]                  chars_mem [sklp_pkg::TableSize*sklp_pkg::MaxNameLen];
   logic [sklp_pkg::LenW:0]     ent_mem   [sklp_pkg::TableSize];
   logic [sklp_pkg::LenW:0]     ent_q_ff;

   always_ff @(posedge clock) begin
      if (chr_we) chars_mem[chr_addr] <= chr_wdata;
      chr_rdata <= chars_mem[chr_addr];
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_addr] <= {ent_wocc, ent_wlen};
      ent_q_ff <= ent_mem[ent_addr];
   end

   assign ent_rocc = ent_q_ff[sklp_pkg::LenW];
   assign ent_rlen = ent_q_ff[sklp_pkg::LenW-1:0];
endmodule

FILE: sv/sklp_ctrl.sv
// Sequencer: key capture, hash fold, probe loop and byte compare.
// Depends on sklp_pkg, the sklp_if interfaces and sklp_store ports; one compare unit reused per byte.
module sklp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   sklp_req_if.sink             req,
   sklp_rsp_if.source           rsp,
   output logic                 chr_we,
   output logic [sklp_pkg::SlotW+sklp_pkg::CharW-1:0] chr_addr,
   output logic [7:0]           chr_wdata,
   input  logic [7:0]           chr_rdata,
   output logic                 ent_we,
   output logic [sklp_pkg::SlotW-1:0] ent_addr,
   output logic [sklp_pkg::LenW-1:0]  ent_wlen,
   output logic                 ent_wocc,
   input  logic [sklp_pkg::LenW-1:0]  ent_rlen,
   input  logic                 ent_rocc
);
   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_ERD = 4'd2, S_EWAIT = 4'd3,
                          S_CHK = 4'd4, S_CWAIT = 4'd5, S_CCMP = 4'd6, S_WR = 4'd7,
                          S_NEXT = 4'd8, S_OUT = 4'd9, S_CRD = 4'd10;

   logic [3:0]                   state_ff, state_in;
   logic [7:0]                   key_ff [sklp_pkg::MaxNameLen];
   logic [sklp_pkg::LenW-1:0]    len_ff, len_in;
   logic [31:0]                  hash_ff, hash_in;
   logic                         long_ff, long_in;
   logic [1:0]                   op_ff, op_in;
   logic [sklp_pkg::SlotW-1:0]   slot_ff, slot_in;
   logic [sklp_pkg::SlotW:0]     cnt_ff, cnt_in;
   logic [sklp_pkg::LenW-1:0]    idx_ff, idx_in;
   logic                         rvalid_ff, rvalid_in;
   sklp_pkg::rsp_type            rdata_ff, rdata_in;
   logic                         take;
   logic [31:0]                  hash_nx;

   assign take    = req.valid && req.ready;
   assign hash_nx = (hash_ff << 5) - hash_ff + {24'd0, req.data.character};
   assign req.ready = (state_ff == S_IDLE) && !rvalid_ff;
   assign rsp.valid = rvalid_ff;
   assign rsp.data  = rdata_ff;

   always_ff @(posedge clock) begin
      if (take && len_ff < sklp_pkg::LenW'(sklp_pkg::MaxNameLen))
         key_ff[len_ff[sklp_pkg::CharW-1:0]] <= req.data.character;
   end

   always_comb begin
      state_in = state_ff; len_in = len_ff; hash_in = hash_ff; long_in = long_ff;
      op_in = op_ff; slot_in = slot_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      rvalid_in = rvalid_ff; rdata_in = rdata_ff;
      chr_we = 1'b0; ent_we = 1'b0; ent_wocc = 1'b0; ent_wlen = len_ff;
      ent_addr = slot_ff;
      chr_addr = {slot_ff, idx_ff[sklp_pkg::CharW-1:0]};
      chr_wdata = key_ff[idx_ff[sklp_pkg::CharW-1:0]];
      if (rvalid_ff && rsp.ready) rvalid_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ent_we = 1'b1;
            slot_in = slot_ff + 1'b1;
            if (slot_ff == sklp_pkg::SlotW'(sklp_pkg::TableSize - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (take) begin
            hash_in = hash_nx;
            if (len_ff < sklp_pkg::LenW'(sklp_pkg::MaxNameLen)) len_in = len_ff + 1'b1;
            else long_in = 1'b1;
            if (req.data.last) begin
               op_in = req.data.opcode;
               slot_in = hash_nx[sklp_pkg::SlotW-1:0];
               cnt_in = '0;
               if (long_ff || len_ff >= sklp_pkg::LenW'(sklp_pkg::MaxNameLen)) begin
                  rdata_in = '{status: sklp_pkg::ST_TOOLONG, slot: '0};
                  state_in = S_OUT;
               end else state_in = S_ERD;
            end
         end
         S_ERD:   state_in = S_EWAIT;
         S_EWAIT: state_in = S_CHK;
         S_CHK: begin
            idx_in = '0;
            if (!ent_rocc) begin
               if (op_ff == sklp_pkg::OP_INSERT) state_in = S_WR;
               else state_in = S_NEXT;
            end else if (ent_rlen != len_ff) state_in = S_NEXT;
            else state_in = S_CRD;
         end
         S_CRD:   state_in = S_CWAIT;
         S_CWAIT: state_in = S_CCMP;
         S_CCMP: begin
            // one byte per pass through the compare unit
            if (chr_rdata != key_ff[idx_ff[sklp_pkg::CharW-1:0]]) state_in = S_NEXT;
            else if (idx_ff + 1'b1 == len_ff) begin
               rdata_in.slot = 12'(slot_ff);
               if (op_ff == sklp_pkg::OP_INSERT) rdata_in.status = sklp_pkg::ST_PRESENT;
               else if (op_ff == sklp_pkg::OP_REMOVE) begin
                  rdata_in.status = sklp_pkg::ST_REMOVED;
                  ent_we = 1'b1;
               end else rdata_in.status = sklp_pkg::ST_FOUND;
               state_in = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_CRD;
            end
         end
         S_WR: begin
            chr_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 >= len_ff) begin
               ent_we = 1'b1; ent_wocc = 1'b1;
               rdata_in = '{status: sklp_pkg::ST_INSERTED, slot: 12'(slot_ff)};
               state_in = S_OUT;
            end
         end
         S_NEXT: begin
            slot_in = slot_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (sklp_pkg::SlotW+1)'(sklp_pkg::TableSize - 1)) begin
               rdata_in.slot = '0;
               rdata_in.status = (op_ff == sklp_pkg::OP_INSERT) ?
                                 sklp_pkg::ST_FULL : sklp_pkg::ST_NOTFOUND;
               state_in = S_OUT;
            end else state_in = S_ERD;
         end
         S_OUT: begin
            rvalid_in = 1'b1;
            len_in = '0; hash_in = '0; long_in = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; len_ff <= '0; hash_ff <= '0; long_ff <= 1'b0;
         rvalid_ff <= 1'b0; slot_ff <= '0;
      end else begin
         state_ff <= state_in; len_ff <= len_in; hash_ff <= hash_in; long_ff <= long_in;
         rvalid_ff <= rvalid_in; slot_ff <= slot_in;
      end
      op_ff <= op_in; cnt_ff <= cnt_in; idx_ff <= idx_in; rdata_ff <= rdata_in;
   end
endmodule

FILE: sv/string_key_linear_probe_table_top.sv
// String-keyed hash table, linear probing, one byte per transfer.
// Each probed slot's entry is read and checked; on a length match the stored bytes are read
// and compared in turn, and an insert stores the name bytes in turn. Over-long names skip probing.
// Throughput: one name at a time; ready low while probing, up to 4096 slots on a miss.
// Reset: synchronous; afterwards a sweep over all 4096 slots clears the occupied bits.
module string_key_linear_probe_table_top (
   input  logic        clock,
   input  logic        reset,
   sklp_req_if.sink    req,
   sklp_rsp_if.source  rsp
);
   logic                 chr_we, ent_we, ent_wocc, ent_rocc;
   logic [sklp_pkg::SlotW+sklp_pkg::CharW-1:0] chr_addr;
   logic [7:0]           chr_wdata, chr_rdata;
   logic [sklp_pkg::SlotW-1:0] ent_addr;
   logic [sklp_pkg::LenW-1:0]  ent_wlen, ent_rlen;

   sklp_ctrl u_ctrl (.clock, .reset, .req, .rsp, .chr_we, .chr_addr, .chr_wdata,
                     .chr_rdata, .ent_we, .ent_addr, .ent_wlen, .ent_wocc,
                     .ent_rlen, .ent_rocc);
   sklp_store u_store (.clock, .chr_we, .chr_addr, .chr_wdata, .chr_rdata, .ent_we,
                       .ent_addr, .ent_wlen, .ent_wocc, .ent_rlen, .ent_rocc);
endmodule

FILE: sv/sklp_checker.sv
// Port-level checks for the table top level.
// Depends on sklp_pkg; bound to string_key_linear_probe_table_top.
module sklp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid, req_ready, req_last,
   input logic rsp_valid, rsp_ready,
   input logic [2:0] rsp_status
);
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= sklp_pkg::ST_TOOLONG) else $error("bad status");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready) else $error("ready after last");
   a_noreq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready with pending rsp");
endmodule

bind string_key_linear_probe_table_top sklp_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .req_last(req.data.last), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.data.status));
